/* hw/rtl/tod_pkg.sv */
// shared constants and register codes for the turnout output pulse driver
package tod_pkg;

    localparam int ADDR_W               = 12;
    localparam int KINDS_W              = 8;
    localparam int DUR_W                = 16;
    localparam int NUM_OUTPUTS          = 8;
    localparam int MAX_SWITCHES         = 4;
    localparam int NUM_SWITCHES_DEFAULT = 4;
    localparam int APB_ADDR_W           = 5;
    localparam int APB_DATA_W           = 32;
    localparam int REG_IDX_W            = 3;

    localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = ADDR_W'(1);
    localparam logic [DUR_W-1:0]  ELAPSED_MAX        = '1;

    localparam logic [1:0] KIND_COIL  = 2'd1;
    localparam logic [1:0] KIND_MOTOR = 2'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SWITCH_KINDS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_FIRST  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_SECOND = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_THIRD  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PULSE_FOURTH = 3'd5;

endpackage

/* hw/rtl/tod_req_if.sv */
// request channel: turnout requests and millisecond ticks
interface tod_req_if
    import tod_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic              output_on;
    logic              direction;

    modport source (output valid, output opcode, output address, output output_on,
                    output direction, input ready);
    modport sink   (input valid, input opcode, input address, input output_on,
                    input direction, output ready);
endinterface

/* hw/rtl/tod_res_if.sv */
// result channel: output levels and request status
interface tod_res_if
    import tod_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [NUM_OUTPUTS-1:0] pin_levels;
    logic                   request_in_range;
    logic                   coil_started;

    modport source (output valid, output pin_levels, output request_in_range,
                    output coil_started, input ready);
    modport sink   (input valid, input pin_levels, input request_in_range,
                    input coil_started, output ready);
endinterface

/* hw/rtl/turnout_output_pulse_driver.sv */
// turnout output pulse driver: request decode, coil pulse timers and motor drive
//
// usage:
//   req carries one transaction per turnout request (opcode request) or per
//   millisecond tick (opcode tick). res returns exactly one transaction per
//   req transaction, in order, with the output levels after that item, the
//   in-range flag and the coil-started flag.
//   the apb port holds base address, switch kinds and four pulse lengths;
//   write it only while no transaction is in flight.
// timing:
//   a req transaction is registered in the input stage at acceptance, and its
//   result in the result stage, which drives res.valid, once that is free.
//   one transaction per cycle is sustained while res is ready; all pulse timers
//   update in parallel in the same single cycle as the address compare.
// reset:
//   all outputs low, no pulse active, timers zero, base address 1, kinds 0,
//   pulse lengths 0; both channel stages empty.
// stall:
//   while res is held off the result register keeps its transaction, the
//   input stage holds one more, and req.ready drops until res drains.
module turnout_output_pulse_driver
    import tod_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    tod_req_if.sink               req,
    tod_res_if.source             res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PINS = 2 * NUM_SWITCHES;
    localparam logic [ADDR_W:0] SWITCH_SPAN = (ADDR_W + 1)'(NUM_SWITCHES);

    // configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [KINDS_W-1:0] kinds_reg;
    logic [DUR_W-1:0]   dur_reg [MAX_SWITCHES];

    // input stage
    logic              s1_valid_reg;
    logic              s1_opcode_reg;
    logic [ADDR_W-1:0] s1_address_reg;
    logic              s1_output_on_reg;
    logic              s1_direction_reg;

    // block state
    logic [NUM_OUTPUTS-1:0] levels_reg;
    logic [NUM_OUTPUTS-1:0] levels_next;
    logic [PINS-1:0]        active_reg;
    logic [PINS-1:0]        active_next;
    logic [DUR_W-1:0]       elapsed_reg  [PINS];
    logic [DUR_W-1:0]       elapsed_next [PINS];

    // result stage
    logic                   res_valid_reg;
    logic [NUM_OUTPUTS-1:0] res_levels_reg;
    logic                   res_in_range_reg;
    logic                   res_started_reg;

    logic             advance;
    logic             cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [ADDR_W:0]  addr_diff;
    logic             in_range;
    logic             started;
    logic [1:0]       sw;
    logic [1:0]       kind;
    logic [2:0]       pin;
    logic [DUR_W-1:0] elapsed_inc;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[REG_IDX_W+1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign advance   = s1_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;

    assign res.valid            = res_valid_reg;
    assign res.pin_levels       = res_levels_reg;
    assign res.request_in_range = res_in_range_reg;
    assign res.coil_started     = res_started_reg;

    // register read
    always_comb
    begin
        case (reg_idx)
            REG_BASE_ADDRESS: prdata = APB_DATA_W'(base_reg);
            REG_SWITCH_KINDS: prdata = APB_DATA_W'(kinds_reg);
            REG_PULSE_FIRST:  prdata = APB_DATA_W'(dur_reg[0]);
            REG_PULSE_SECOND: prdata = APB_DATA_W'(dur_reg[1]);
            REG_PULSE_THIRD:  prdata = APB_DATA_W'(dur_reg[2]);
            REG_PULSE_FOURTH: prdata = APB_DATA_W'(dur_reg[3]);
            default:          prdata = '0;
        endcase
    end

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_ADDRESS_RESET;
            kinds_reg <= '0;
            for (int i = 0; i < MAX_SWITCHES; i++)
            begin
                dur_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_BASE_ADDRESS: base_reg   <= pwdata[ADDR_W-1:0];
                REG_SWITCH_KINDS: kinds_reg  <= pwdata[KINDS_W-1:0];
                REG_PULSE_FIRST:  dur_reg[0] <= pwdata[DUR_W-1:0];
                REG_PULSE_SECOND: dur_reg[1] <= pwdata[DUR_W-1:0];
                REG_PULSE_THIRD:  dur_reg[2] <= pwdata[DUR_W-1:0];
                REG_PULSE_FOURTH: dur_reg[3] <= pwdata[DUR_W-1:0];
                default:          ;
            endcase
        end
    end

    // request decode
    assign addr_diff = {1'b0, s1_address_reg} - {1'b0, base_reg};
    assign in_range  = (s1_opcode_reg == OP_REQUEST) && !addr_diff[ADDR_W]
                       && (addr_diff < SWITCH_SPAN);
    assign sw        = addr_diff[1:0];
    assign kind      = 2'(kinds_reg >> {sw, 1'b0});
    assign pin       = {sw, ~s1_direction_reg};

    // next state for one item
    always_comb
    begin
        levels_next  = levels_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        started      = 1'b0;
        elapsed_inc  = '0;
        if (s1_opcode_reg == OP_TICK)
        begin
            for (int p = 0; p < PINS; p++)
            begin
                if (active_reg[p])
                begin
                    elapsed_inc = (elapsed_reg[p] == ELAPSED_MAX) ? elapsed_reg[p]
                                                                  : elapsed_reg[p] + 1'b1;
                    elapsed_next[p] = elapsed_inc;
                    if (elapsed_inc >= dur_reg[p >> 1])
                    begin
                        levels_next[p] = 1'b0;
                        active_next[p] = 1'b0;
                    end
                end
            end
        end
        else if (in_range && s1_output_on_reg)
        begin
            for (int p = 0; p < PINS; p++)
            begin
                if (kind == KIND_COIL && 3'(p) == pin && !active_reg[p])
                begin
                    active_next[p]  = 1'b1;
                    elapsed_next[p] = '0;
                    levels_next[p]  = 1'b1;
                    started         = 1'b1;
                end
                else if (kind == KIND_MOTOR && 2'(p >> 1) == sw)
                begin
                    levels_next[p] = (p % 2 == 1) ? !s1_direction_reg : s1_direction_reg;
                end
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_opcode_reg    <= req.opcode;
            s1_address_reg   <= req.address;
            s1_output_on_reg <= req.output_on;
            s1_direction_reg <= req.direction;
        end
    end

    // state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= '0;
            active_reg    <= '0;
            res_valid_reg <= 1'b0;
            for (int p = 0; p < PINS; p++)
            begin
                elapsed_reg[p] <= '0;
            end
        end
        else if (advance)
        begin
            levels_reg    <= levels_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_levels_reg   <= levels_next;
            res_in_range_reg <= in_range;
            res_started_reg  <= started;
        end
    end

endmodule

/* test/tod_checker.sv */
// checker for the turnout output pulse driver: tracks registers, predicts and compares results
module tod_checker
    import tod_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tod_req_if                    req,
    tod_res_if                    res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int SWITCHES = NUM_SWITCHES_DEFAULT;

    typedef struct packed {
        logic [NUM_OUTPUTS-1:0] pin_levels;
        logic                   request_in_range;
        logic                   coil_started;
    } turnout_result_t;

    logic [ADDR_W-1:0]      base_address;
    logic [KINDS_W-1:0]     switch_kinds;
    logic [DUR_W-1:0]       pulse_ms [MAX_SWITCHES];
    logic [NUM_OUTPUTS-1:0] levels;
    logic [NUM_OUTPUTS-1:0] active;
    logic [DUR_W-1:0]       elapsed [NUM_OUTPUTS];
    turnout_result_t        pending_results [$];

    initial mismatches = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t checker: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic turnout_result_t apply_turnout_item(input logic op,
                                                           input logic [ADDR_W-1:0] addr,
                                                           input logic on,
                                                           input logic dir);
        turnout_result_t r;
        int              sw;
        int              pin;
        logic [1:0]      kind;
        logic [DUR_W-1:0] e;
        r = '0;
        if (op == OP_TICK)
        begin
            for (int p = 0; p < 2 * SWITCHES; p++)
            begin
                if (active[p])
                begin
                    e = elapsed[p];
                    if (e != ELAPSED_MAX)
                        e = e + 1'b1;
                    elapsed[p] = e;
                    if (e >= pulse_ms[p / 2])
                    begin
                        levels[p] = 1'b0;
                        active[p] = 1'b0;
                    end
                end
            end
        end
        else if (int'(addr) >= int'(base_address) &&
                 int'(addr) < int'(base_address) + SWITCHES)
        begin
            sw = int'(addr) - int'(base_address);
            r.request_in_range = 1'b1;
            if (on)
            begin
                kind = switch_kinds[2 * sw +: 2];
                if (kind == KIND_COIL)
                begin
                    pin = 2 * sw + (dir ? 0 : 1);
                    if (!active[pin])
                    begin
                        active[pin]    = 1'b1;
                        elapsed[pin]   = '0;
                        levels[pin]    = 1'b1;
                        r.coil_started = 1'b1;
                    end
                end
                else if (kind == KIND_MOTOR)
                begin
                    levels[2 * sw]     = dir;
                    levels[2 * sw + 1] = !dir;
                end
            end
        end
        r.pin_levels = levels;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        turnout_result_t want;
        if (!rst_n)
        begin
            base_address = BASE_ADDRESS_RESET;
            switch_kinds = '0;
            levels       = '0;
            active       = '0;
            for (int i = 0; i < MAX_SWITCHES; i++)
                pulse_ms[i] = '0;
            for (int i = 0; i < NUM_OUTPUTS; i++)
                elapsed[i] = '0;
            pending_results.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with none pending, pin_levels", res.pin_levels, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (res.pin_levels !== want.pin_levels)
                        flag_mismatch("pin_levels", res.pin_levels, want.pin_levels);
                    if (res.request_in_range !== want.request_in_range)
                        flag_mismatch("request_in_range", res.request_in_range,
                                      want.request_in_range);
                    if (res.coil_started !== want.coil_started)
                        flag_mismatch("coil_started", res.coil_started, want.coil_started);
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_turnout_item(req.opcode, req.address,
                                                             req.output_on, req.direction));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_BASE_ADDRESS: base_address = pwdata[ADDR_W-1:0];
                    REG_SWITCH_KINDS: switch_kinds = pwdata[KINDS_W-1:0];
                    REG_PULSE_FIRST:  pulse_ms[0]  = pwdata[DUR_W-1:0];
                    REG_PULSE_SECOND: pulse_ms[1]  = pwdata[DUR_W-1:0];
                    REG_PULSE_THIRD:  pulse_ms[2]  = pwdata[DUR_W-1:0];
                    REG_PULSE_FOURTH: pulse_ms[3]  = pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_results.size();
    end

endmodule

/* test/testbench.sv */
// testbench top for the turnout output pulse driver: reset, register setup, stimulus, verdict
module testbench;
    import tod_pkg::*;

    localparam logic [1:0] KIND_IGNORED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    src_idle_pct = 0;
    int                    sink_stall_pct = 0;
    int                    mismatches;
    int                    outstanding;
    logic [ADDR_W-1:0]     cur_base = BASE_ADDRESS_RESET;

    tod_req_if req_ch ();
    tod_res_if res_ch ();

    turnout_output_pulse_driver DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tod_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    initial
    begin
        #(8 * 2_000_000);
        $display("turnout_output_pulse_driver: mismatch");
        $finish;
    end

    task automatic drain();
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_BASE_ADDRESS)
            cur_base = value[ADDR_W-1:0];
    endtask

    task automatic send(input logic op, input logic [ADDR_W-1:0] addr,
                        input logic on, input logic dir);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.opcode    = op;
        req_ch.address   = addr;
        req_ch.output_on = on;
        req_ch.direction = dir;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        int                pick;
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic              on;
        pick = $urandom_range(99);
        op   = (pick < 40) ? OP_TICK : OP_REQUEST;
        on   = ($urandom_range(99) < 85);
        if (pick < 40)
            addr = ADDR_W'($urandom_range(0, 2048));
        else if (pick < 85)
            addr = cur_base + ADDR_W'($urandom_range(0, 3));
        else if (pick < 92)
            addr = $urandom_range(1) ? cur_base - 1'b1 : cur_base + ADDR_W'(4);
        else
            addr = ADDR_W'($urandom_range(0, 2048));
        send(op, addr, on, 1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [ADDR_W-1:0] base,
                             input int items);
        drain();
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        write_reg(REG_BASE_ADDRESS, APB_DATA_W'(base));
        write_reg(REG_SWITCH_KINDS, $urandom_range(0, 255));
        write_reg(REG_PULSE_FIRST, $urandom_range(0, 5));
        write_reg(REG_PULSE_SECOND, $urandom_range(0, 5));
        write_reg(REG_PULSE_THIRD, $urandom_range(0, 8));
        write_reg(REG_PULSE_FOURTH, $urandom_range(1, 3));
        for (int i = 0; i < items; i++)
        begin
            if (i == items / 2)
                drain();
            send_random();
        end
    endtask

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_REQUEST;
        req_ch.address   = '0;
        req_ch.output_on = 1'b0;
        req_ch.direction = 1'b0;
        res_ch.ready     = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: every kind ignored
        send(OP_REQUEST, 1, 1'b1, 1'b1);
        send(OP_TICK, 0, 1'b0, 1'b0);

        drain();
        write_reg(REG_BASE_ADDRESS, 0);
        write_reg(REG_SWITCH_KINDS,
                  APB_DATA_W'({KIND_COIL, KIND_IGNORED, KIND_MOTOR, KIND_COIL}));
        write_reg(REG_PULSE_FIRST, 0);
        write_reg(REG_PULSE_SECOND, 3);
        write_reg(REG_PULSE_THIRD, 16'hFFFF);
        write_reg(REG_PULSE_FOURTH, 16'hFFFF);

        send(OP_REQUEST, 0, 1'b1, 1'b1);
        send(OP_REQUEST, 0, 1'b1, 1'b1);
        send(OP_REQUEST, 0, 1'b1, 1'b0);
        send(OP_TICK, 0, 1'b0, 1'b0);
        send(OP_REQUEST, 1, 1'b1, 1'b1);
        send(OP_REQUEST, 1, 1'b1, 1'b0);
        send(OP_REQUEST, 2, 1'b1, 1'b1);
        send(OP_REQUEST, 3, 1'b0, 1'b1);
        send(OP_REQUEST, 3, 1'b1, 1'b1);
        send(OP_REQUEST, 4, 1'b1, 1'b1);
        send(OP_REQUEST, 2048, 1'b1, 1'b0);

        // long pulse keeps running across many ticks
        repeat (100) send(OP_TICK, 12'hFFF, 1'b1, 1'b1);

        // motor drive over a running coil pulse, then shorten the pulse
        send(OP_REQUEST, 3, 1'b1, 1'b1);
        send(OP_TICK, 0, 1'b0, 1'b0);
        drain();
        write_reg(REG_SWITCH_KINDS,
                  APB_DATA_W'({KIND_MOTOR, KIND_IGNORED, KIND_MOTOR, KIND_COIL}));
        send(OP_REQUEST, 3, 1'b1, 1'b0);
        send(OP_REQUEST, 3, 1'b1, 1'b1);
        drain();
        write_reg(REG_PULSE_FOURTH, 2);
        send(OP_TICK, 0, 1'b0, 1'b0);
        send(OP_TICK, 0, 1'b0, 1'b0);

        run_phase(0, 0, 0, 250);
        run_phase(45, 0, ADDR_W'($urandom_range(0, 2048)), 250);
        run_phase(0, 45, 2048, 250);
        run_phase(38, 38, 2044, 250);

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("turnout_output_pulse_driver: match");
        else
            $display("turnout_output_pulse_driver: mismatch");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tod_pkg.sv
hw/rtl/tod_req_if.sv
hw/rtl/tod_res_if.sv
hw/rtl/turnout_output_pulse_driver.sv
test/tod_checker.sv
test/testbench.sv
